// ===== src/keyboard_command_line_decoder_defines.svh =====
// Assertion macros for the keyboard command line decoder.
`ifndef KEYBOARD_COMMAND_LINE_DECODER_DEFINES_SVH
`define KEYBOARD_COMMAND_LINE_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define KCLD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m");
`define KCLD_ASSERT_R(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m");
`else
`define KCLD_ASSERT(label, clk, rst, prop)
`define KCLD_ASSERT_R(label, clk, prop)
`endif
`endif

// ===== src/kcld_pkg.sv =====
// Package: constants, types and codes of the keyboard command line decoder.
package kcld_pkg;
   localparam int LINE_CHARS    = 32;
   localparam int ID_CHARS      = 8;
   localparam int TABLE_ENTRIES = 8;
   localparam int LINE_AW  = $clog2(LINE_CHARS);
   localparam int LEN_W    = $clog2(LINE_CHARS + 1);
   localparam int TAB_AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W    = $clog2(ID_CHARS + 1);
   localparam int IDB_W    = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
   localparam int ENT_W    = 64 + 4 + 8;

   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_NUL = 8'd0;

   localparam logic CSR_PROMPT = 1'b0;
   localparam logic CSR_ERASE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ECHO, ST_CR, ST_LF, ST_SCAN_RD, ST_SCAN_CMP, ST_SEND_RD, ST_SEND
   } state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       dest;
      logic [7:0] target;
      logic       last;
   } rsp_type;
endpackage

// ===== src/kcld_ram.sv =====
// Generic single-port-write RAM with registered read.
module kcld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/keyboard_command_line_decoder.sv =====
// Keyboard command line decoder: top level with sequencer and compare unit.
// Registration: no result. Keystroke: 1 echo result.
// Enter: CR, LF, then per table entry a compare of the identifier bytes, then
//   a line memory read and a send for each line character sent to the owner.
// One item at a time; req_tready is high only when idle and no result is waiting.
// Synchronous active-high reset clears line length, table count and result valid,
//   loads default prompt and erase codes; line and table memories are not cleared.
`include "keyboard_command_line_decoder_defines.svh"
module keyboard_command_line_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // action
   // [7:0] key_char, [71:8] command_text, [75:72] command_length, [83:76] owner_id
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_char, [15:8] target_id
   output logic        rsp_tuser,   // destination
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   localparam int LA = kcld_pkg::LINE_AW;
   localparam int LW = kcld_pkg::LEN_W;
   localparam int TA = kcld_pkg::TAB_AW;
   localparam int CW = kcld_pkg::CNT_W;
   localparam int IW = kcld_pkg::IDX_W;

   kcld_pkg::state_type state_ff, state_in;
   logic [7:0]  prompt_ff, erase_ff;
   logic [LW-1:0] len_ff, len_in, snap_ff, snap_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ent_ff, ent_in;   // entry under test
   logic [IW-1:0] pos_ff, pos_in;   // identifier byte under test
   logic [LW-1:0] k_ff, k_in;       // line char being sent
   logic [7:0]  key_ff;
   logic [7:0]  first_ff;           // first buffered char
   logic        keep_ff;            // line starts with prompt, taken at enter
   kcld_pkg::rsp_type out_ff, out_in;
   logic        ov_ff, ov_in;

   // line memory
   logic          lw_en;
   logic [LA-1:0] lw_addr, lr_addr;
   logic [7:0]    lr_data;
   // table memory
   logic          tw_en;
   logic [kcld_pkg::ENT_W-1:0] tw_data, tr_data;
   logic [TA-1:0] tr_addr;

   logic        accept, is_enter;
   logic [7:0]  rkey;
   logic [63:0] kept;
   logic [3:0]  nkept, clen;
   logic [63:0] e_text;
   logic [3:0]  e_len;
   logic [7:0]  e_owner, id_b;

   assign accept    = req_tvalid && req_tready;
   assign rkey      = req_tdata[7:0];
   assign csr_ready = 1'b1;
   assign is_enter  = (key_ff == kcld_pkg::CH_CR) || (key_ff == kcld_pkg::CH_LF)
                   || (key_ff == kcld_pkg::CH_NUL);
   assign {e_owner, e_len, e_text} = tr_data;
   assign id_b = e_text[8*pos_ff[kcld_pkg::IDB_W-1:0] +: 8];

   // Identifier trim: up to ID_CHARS bytes and command_length, stop at first zero.
   always_comb begin
      logic stop;
      kept  = '0;
      nkept = '0;
      stop  = 1'b0;
      clen  = req_tdata[75:72];
      for (int j = 0; j < kcld_pkg::ID_CHARS; j++) begin
         if (!stop && (4'(j) < clen) && (req_tdata[8+8*j +: 8] != 8'd0)) begin
            kept[8*j +: 8] = req_tdata[8+8*j +: 8];
            nkept = nkept + 4'd1;
         end else begin
            stop = 1'b1;
         end
      end
   end

   assign tw_en   = accept && req_tuser && (cnt_ff < CW'(kcld_pkg::TABLE_ENTRIES));
   assign tw_data = {req_tdata[83:76], nkept, kept};

   kcld_ram #(.WIDTH(kcld_pkg::ENT_W), .DEPTH(kcld_pkg::TABLE_ENTRIES)) u_table (
      .clock, .wr_en(tw_en), .wr_addr(cnt_ff[TA-1:0]), .wr_data(tw_data),
      .rd_addr(tr_addr), .rd_data(tr_data));

   assign lw_en   = accept && !req_tuser && (rkey != kcld_pkg::CH_CR)
                 && (rkey != kcld_pkg::CH_LF) && (rkey != kcld_pkg::CH_NUL)
                 && (rkey != erase_ff) && (len_ff < LW'(kcld_pkg::LINE_CHARS - 1));
   assign lw_addr = len_ff[LA-1:0];

   kcld_ram #(.WIDTH(8), .DEPTH(kcld_pkg::LINE_CHARS)) u_line (
      .clock, .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(rkey),
      .rd_addr(lr_addr), .rd_data(lr_data));

   assign tr_addr = ent_ff[TA-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kcld_pkg::ST_IDLE:
            if (accept && !req_tuser) state_in = kcld_pkg::ST_ECHO;
         kcld_pkg::ST_ECHO:
            state_in = is_enter ? kcld_pkg::ST_CR : kcld_pkg::ST_IDLE;
         kcld_pkg::ST_CR:
            if (!ov_ff) state_in = kcld_pkg::ST_LF;
         kcld_pkg::ST_LF:
            if (!ov_ff) state_in = kcld_pkg::ST_SCAN_RD;
         kcld_pkg::ST_SCAN_RD:
            if (!ov_ff) begin
               if (snap_ff == '0 || !keep_ff || ent_ff >= cnt_ff)
                  state_in = kcld_pkg::ST_IDLE;
               else
                  state_in = kcld_pkg::ST_SCAN_CMP;
            end
         kcld_pkg::ST_SCAN_CMP:
            if (pos_ff == IW'(0) && snap_ff < LW'(e_len) + LW'(1))
               state_in = kcld_pkg::ST_SCAN_RD;
            else if (pos_ff == IW'(e_len))
               state_in = kcld_pkg::ST_SEND_RD;
            else if (lr_data != id_b)
               state_in = kcld_pkg::ST_SCAN_RD;
         kcld_pkg::ST_SEND_RD:
            if (!ov_ff) state_in = kcld_pkg::ST_SEND;
         kcld_pkg::ST_SEND:
            state_in = (k_ff == snap_ff) ? kcld_pkg::ST_IDLE : kcld_pkg::ST_SEND_RD;
         default: state_in = kcld_pkg::ST_IDLE;
      endcase
   end

   // Datapath / outputs
   always_comb begin
      len_in  = len_ff;
      snap_in = snap_ff;
      cnt_in  = cnt_ff;
      ent_in  = ent_ff;
      pos_in  = pos_ff;
      k_in    = k_ff;
      out_in  = out_ff;
      ov_in   = ov_ff && !rsp_tready;
      lr_addr = '0;
      req_tready = (state_ff == kcld_pkg::ST_IDLE) && !ov_ff;
      case (state_ff)
         kcld_pkg::ST_IDLE:
            if (tw_en) cnt_in = cnt_ff + CW'(1);
         kcld_pkg::ST_ECHO:
            if (is_enter) begin
               snap_in = len_ff;
               len_in  = '0;
               ent_in  = '0;
            end else begin
               out_in = '{ch: key_ff, dest: 1'b0, target: 8'd0, last: 1'b1};
               ov_in  = 1'b1;
               if (key_ff == erase_ff) begin
                  if (len_ff != '0) len_in = len_ff - LW'(1);
               end else if (len_ff < LW'(kcld_pkg::LINE_CHARS - 1)) begin
                  len_in = len_ff + LW'(1);
               end
            end
         kcld_pkg::ST_CR:
            if (!ov_ff) begin
               out_in = '{ch: kcld_pkg::CH_CR, dest: 1'b0, target: 8'd0, last: 1'b0};
               ov_in  = 1'b1;
            end
         kcld_pkg::ST_LF:
            if (!ov_ff) begin
               // not last yet; the LF is held and marked last below if the scan sends nothing
               out_in = '{ch: kcld_pkg::CH_LF, dest: 1'b0, target: 8'd0, last: 1'b0};
            end
         kcld_pkg::ST_SCAN_RD: begin
            pos_in  = '0;
            lr_addr = LA'(1);
            if (!ov_ff && (snap_ff == '0 || !keep_ff || ent_ff >= cnt_ff)) begin
               out_in.last = 1'b1;
               ov_in = 1'b1;
            end
         end
         kcld_pkg::ST_SCAN_CMP: begin
            lr_addr = LA'(pos_ff + IW'(2));
            if (pos_ff == IW'(0) && snap_ff < LW'(e_len) + LW'(1)) begin
               ent_in = ent_ff + CW'(1);
            end else if (pos_ff == IW'(e_len)) begin
               ov_in = 1'b1;     // release the held LF
               k_in  = '0;
            end else if (lr_data != id_b) begin
               ent_in = ent_ff + CW'(1);
            end else begin
               pos_in = pos_ff + IW'(1);
            end
         end
         kcld_pkg::ST_SEND_RD:
            lr_addr = k_ff[LA-1:0];
         kcld_pkg::ST_SEND: begin
            out_in = '{ch: lr_data, dest: 1'b1, target: e_owner,
                       last: (k_ff + LW'(1) == snap_ff)};
            ov_in  = 1'b1;
            k_in   = k_ff + LW'(1);
            lr_addr = k_ff[LA-1:0];
         end
         default: ;
      endcase
      if (state_ff == kcld_pkg::ST_SEND && k_ff == snap_ff) begin
         out_in = out_ff;
         ov_in  = ov_ff && !rsp_tready;
      end
   end

   // Compare uses lr_data of address pos+1 (registered): at pos==0 the read
   // of address 1 is issued in SCAN_RD; each step reads the next byte.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kcld_pkg::ST_IDLE;
         prompt_ff <= 8'd37;
         erase_ff  <= 8'd8;
         len_ff    <= '0;
         cnt_ff    <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == kcld_pkg::CSR_PROMPT) prompt_ff <= csr_data;
            else                                   erase_ff  <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      ent_ff  <= ent_in;
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      out_ff  <= out_in;
      if (accept) key_ff <= rkey;
      if (lw_en && len_ff == '0) first_ff <= rkey;
      if (state_ff == kcld_pkg::ST_ECHO && is_enter)
         keep_ff <= (first_ff == prompt_ff) && (len_ff != '0);
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {out_ff.target, out_ff.ch};
   assign rsp_tuser  = out_ff.dest;
   assign rsp_tlast  = out_ff.last;

   `KCLD_ASSERT(a_busy_no_ready, clock, reset, (state_ff != kcld_pkg::ST_IDLE) |-> !req_tready)
   `KCLD_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(kcld_pkg::TABLE_ENTRIES))
   `KCLD_ASSERT(a_len_bound, clock, reset, len_ff < LW'(kcld_pkg::LINE_CHARS))
   `KCLD_ASSERT_R(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid)
endmodule

// ===== tb/sv/keyboard_command_line_decoder_tb.sv =====
// Self-checking testbench of the keyboard command line decoder.
`timescale 1ns / 100ps
module keyboard_command_line_decoder_tb;

   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 200;   // above the worst enter latency
   localparam int STALL_LIMIT  = 4000;  // cycles without any transfer

   typedef struct {
      logic        action;
      logic [7:0]  key;
      logic [63:0] text;
      logic [3:0]  len;
      logic [7:0]  owner;
      int          ntyped;   // 0: use the line predictor
      kcld_pkg::rsp_type typed[2];
   } key_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = kcld_pkg::CSR_PROMPT;
   logic [7:0]  csr_data = '0;

   keyboard_command_line_decoder DUT (.*);

   always #10 clock = ~clock;

   // Shadow copy of the decoder: registers, line buffer and command table.
   logic [7:0]  sh_prompt, sh_erase;
   logic [7:0]  sh_line [kcld_pkg::LINE_CHARS];
   int          sh_line_len;
   logic [63:0] sh_cmd_text [kcld_pkg::TABLE_ENTRIES];
   int          sh_cmd_len [kcld_pkg::TABLE_ENTRIES];
   logic [7:0]  sh_cmd_owner [kcld_pkg::TABLE_ENTRIES];
   int          sh_cmd_count;

   kcld_pkg::rsp_type expected_chars[$];   // results still owed by the block
   key_item_type      sent_items[$];       // items offered, popped on transfer
   int          errors = 0, n_items = 0, n_results = 0, n_matches = 0;
   int          quiet_cycles = 0;
   bit          no_idle = 1'b0, hold_req = 1'b0;

   function automatic kcld_pkg::rsp_type mk(logic [7:0] ch, logic dest, logic [7:0] tgt,
                                            logic lst);
      kcld_pkg::rsp_type r;
      r.ch = ch; r.dest = dest; r.target = tgt; r.last = lst;
      return r;
   endfunction

   function automatic bit is_enter(logic [7:0] c);
      return c == kcld_pkg::CH_CR || c == kcld_pkg::CH_LF || c == kcld_pkg::CH_NUL;
   endfunction

   // Line decoder predictor: updates the shadow and appends expected chars.
   task automatic decode_line(input key_item_type it, ref kcld_pkg::rsp_type outq[$]);
      int n, len, e, j;
      bit hit;
      logic [7:0] b;
      if (it.action) begin
         if (sh_cmd_count < kcld_pkg::TABLE_ENTRIES) begin
            len = (it.len > kcld_pkg::ID_CHARS) ? kcld_pkg::ID_CHARS : int'(it.len);
            n = 0;
            sh_cmd_text[sh_cmd_count] = '0;
            for (j = 0; j < len; j++) begin
               b = it.text[j*8 +: 8];
               if (b == 8'd0) break;
               sh_cmd_text[sh_cmd_count][j*8 +: 8] = b;
               n++;
            end
            sh_cmd_len[sh_cmd_count]   = n;
            sh_cmd_owner[sh_cmd_count] = it.owner;
            sh_cmd_count++;
         end
         return;
      end
      if (is_enter(it.key)) begin
         len = sh_line_len;
         sh_line_len = 0;
         outq.push_back(mk(kcld_pkg::CH_CR, 1'b0, 8'd0, 1'b0));
         outq.push_back(mk(kcld_pkg::CH_LF, 1'b0, 8'd0, 1'b0));
         if (len >= 1 && sh_line[0] == sh_prompt) begin
            for (e = 0; e < sh_cmd_count; e++) begin
               hit = (len >= sh_cmd_len[e] + 1);
               for (j = 0; hit && j < sh_cmd_len[e]; j++)
                  if (sh_line[j+1] != sh_cmd_text[e][j*8 +: 8]) hit = 0;
               if (hit) begin
                  n_matches++;
                  for (j = 0; j < len; j++)
                     outq.push_back(mk(sh_line[j], 1'b1, sh_cmd_owner[e], 1'b0));
                  break;
               end
            end
         end
      end else begin
         outq.push_back(mk(it.key, 1'b0, 8'd0, 1'b0));
         if (it.key == sh_erase) begin
            if (sh_line_len > 0) sh_line_len--;
         end else if (sh_line_len < kcld_pkg::LINE_CHARS - 1) begin
            sh_line[sh_line_len] = it.key;
            sh_line_len++;
         end
      end
      outq[$].last = 1'b1;
   endtask

   // Monitor: predicts on every input transfer, checks every result transfer.
   always @(posedge clock) begin
      key_item_type      it;
      kcld_pkg::rsp_type got, want;
      kcld_pkg::rsp_type pred[$];
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = mk(rsp_tdata[7:0], rsp_tuser, rsp_tdata[15:8], rsp_tlast);
            n_results++;
            if (expected_chars.size() == 0) begin
               $error("unexpected result transfer: out_char %0d", got.ch);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (got.ch != want.ch) begin
                  $error("out_char: expected %0d, got %0d", want.ch, got.ch);
                  errors++;
               end
               if (got.dest != want.dest) begin
                  $error("destination: expected %0d, got %0d", want.dest, got.dest);
                  errors++;
               end
               if (got.target != want.target) begin
                  $error("target_id: expected %0d, got %0d", want.target, got.target);
                  errors++;
               end
               if (got.last != want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it = sent_items.pop_front();
            n_items++;
            pred.delete();
            decode_line(it, pred);
            if (it.ntyped > 0)
               for (int k = 0; k < it.ntyped; k++) expected_chars.push_back(it.typed[k]);
            else
               foreach (pred[k]) expected_chars.push_back(pred[k]);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == kcld_pkg::CSR_PROMPT) sh_prompt = csr_data;
            else                                   sh_erase  = csr_data;
         end
      end
   end

   // Watchdog: no transfer of any kind for too long.
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("** keyboard_command_line_decoder: FAILED **");
      $finish;
   end

   // Receiver: random ready bursts, one long hold-off on request.
   initial begin
      int n;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req   = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            n = $urandom_range(1, 12);
            rsp_tready = no_idle || ($urandom_range(0, 3) != 0);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // One input transfer, with an optional random gap before it.
   task automatic send(input key_item_type it);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      sent_items.push_back(it);
      req_tuser  = it.action;
      req_tdata  = {4'd0, it.owner, it.len, it.text, it.key};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic key_item_type keystroke(logic [7:0] c);
      key_item_type it;
      it.action = 1'b0; it.key = c;
      it.text = {$urandom, $urandom}; it.len = 4'($urandom_range(0, 8));
      it.owner = 8'($urandom); it.ntyped = 0;
      return it;
   endfunction

   function automatic key_item_type reg_cmd(logic [63:0] txt, logic [3:0] l,
                                            logic [7:0] own);
      key_item_type it;
      it.action = 1'b1; it.key = 8'($urandom); it.text = txt;
      it.len = l; it.owner = own; it.ntyped = 0;
      return it;
   endfunction

   // Wait until the block is idle, then write both registers.
   task automatic set_regs(input logic [7:0] prompt, input logic [7:0] erase);
      wait (expected_chars.size() == 0 && sent_items.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      for (int r = 0; r < 2; r++) begin
         csr_index = (r == 0) ? kcld_pkg::CSR_PROMPT : kcld_pkg::CSR_ERASE;
         csr_data  = (r == 0) ? prompt : erase;
         csr_valid = 1'b1;
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
         csr_valid = 1'b0;
      end
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom); while (is_enter(c) || c == sh_erase);
      return c;
   endfunction

   // A command line: mostly prompt + known identifier + tail, then enter.
   task automatic send_line();
      int e, extra;
      logic [7:0] enter_codes [3];
      enter_codes = '{kcld_pkg::CH_CR, kcld_pkg::CH_LF, kcld_pkg::CH_NUL};
      if ($urandom_range(0, 9) < 8) send(keystroke(sh_prompt));
      if (sh_cmd_count > 0 && $urandom_range(0, 3) != 0) begin
         e = $urandom_range(0, sh_cmd_count - 1);
         for (int j = 0; j < sh_cmd_len[e]; j++)
            if (j + 1 < sh_cmd_len[e] || $urandom_range(0, 5) != 0)
               send(keystroke(sh_cmd_text[e][j*8 +: 8]));
      end
      extra = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 5);
      for (int j = 0; j < extra; j++)
         send(keystroke(($urandom_range(0, 7) == 0) ? sh_erase : plain_char()));
      send(keystroke(enter_codes[$urandom_range(0, 2)]));
   endtask

   key_item_type directed[$];

   initial begin
      key_item_type it;
      int phase;
      sh_prompt = 8'd37; sh_erase = 8'd8; sh_line_len = 0; sh_cmd_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows; plain enters and two echoes carry typed expectations.
      it = keystroke(kcld_pkg::CH_CR);  it.ntyped = 2;
      it.typed = '{mk(kcld_pkg::CH_CR, 1'b0, 8'd0, 1'b0),
                   mk(kcld_pkg::CH_LF, 1'b0, 8'd0, 1'b1)};
      directed.push_back(it);
      it.key = kcld_pkg::CH_NUL; directed.push_back(it);
      it.key = kcld_pkg::CH_LF;  directed.push_back(it);
      it = keystroke(8'd8);   it.ntyped = 1;   // erase on empty line
      it.typed[0] = mk(8'd8, 1'b0, 8'd0, 1'b1); directed.push_back(it);
      it = keystroke(8'hFF);  it.ntyped = 1;
      it.typed[0] = mk(8'hFF, 1'b0, 8'd0, 1'b1); directed.push_back(it);
      it = keystroke(kcld_pkg::CH_CR);  it.ntyped = 2;   // line "\xff" has no prompt
      it.typed = '{mk(kcld_pkg::CH_CR, 1'b0, 8'd0, 1'b0),
                   mk(kcld_pkg::CH_LF, 1'b0, 8'd0, 1'b1)};
      directed.push_back(it);
      directed.push_back(reg_cmd(64'h6261, 4'd2, 8'd5));                 // "ab"
      directed.push_back(reg_cmd(64'h0000_0000_0079_0078, 4'd3, 8'd7)); // zero byte cut
      directed.push_back(reg_cmd({8{8'hFF}}, 4'd15, 8'hAA));          // over-long
      directed.push_back(reg_cmd(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'h00));
      directed.push_back(keystroke("%"));
      directed.push_back(keystroke("a"));
      directed.push_back(keystroke("b"));
      directed.push_back(keystroke("c"));
      directed.push_back(keystroke(kcld_pkg::CH_CR));                   // matches "ab"
      directed.push_back(keystroke("%"));
      directed.push_back(keystroke("x"));
      directed.push_back(keystroke(8'd8));
      directed.push_back(keystroke("z"));
      it = keystroke(kcld_pkg::CH_LF); it.ntyped = 2;                   // no match
      it.typed = '{mk(kcld_pkg::CH_CR, 1'b0, 8'd0, 1'b0),
                   mk(kcld_pkg::CH_LF, 1'b0, 8'd0, 1'b1)};
      directed.push_back(it);
      foreach (directed[k]) send(directed[k]);

      // Random phases across register settings; the last runs without idling.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_regs(8'd0,   8'hFF);
            1: set_regs(8'hFF,  8'd0);    // erase equal to NUL: enter wins
            2: set_regs(8'h41,  kcld_pkg::CH_CR);
            3: set_regs(8'd37,  8'h7F);
            default: begin
               set_regs(8'd37, 8'd8);
               no_idle = 1'b1;
            end
         endcase
         if (phase == 2) begin
            // Long receiver stall while lines keep coming.
            @(negedge clock);
            hold_req = 1'b1;
         end
         while (n_items < 18 + 30 * (phase + 1)) begin
            case ($urandom_range(0, 9))
               0: send(reg_cmd({$urandom, $urandom} & {8{8'h7F}},
                               4'($urandom_range(0, 8)), 8'($urandom)));
               1: send(keystroke(8'($urandom)));
               2: begin
                  it = reg_cmd({$urandom, $urandom}, 4'($urandom_range(0, 8)),
                               8'($urandom));
                  it.action = 1'b0;
                  send(it);
               end
               default: send_line();
            endcase
         end
      end

      wait (expected_chars.size() == 0 && sent_items.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d input transfers and %0d result transfers, %0d command matches,",
               n_items, n_results, n_matches);
      $display("five register settings, a full command table and full lines.");
      if (errors == 0 && expected_chars.size() == 0)
         $display("** keyboard_command_line_decoder: PASSED **");
      else
         $display("** keyboard_command_line_decoder: FAILED **");
      $finish;
   end
endmodule
